// ===== hdl/pvalu_pkg.sv =====
// Package with shared types, opcodes and constants for the packed vector ALU.
package pvalu_pkg;

   localparam int LANES = 8;
   localparam int LANE_W = 32;
   localparam int DIV_STEPS = 4;   // quotient bits resolved per divider stage
   localparam int DIV_STAGES = LANE_W / DIV_STEPS;
   localparam logic [LANE_W-1:0] LANE_ONES = 32'hFFFFFFFF;

   typedef logic [LANE_W-1:0] lane_type;
   typedef lane_type [LANES-1:0] vec_type;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_REM = 4'd4,
      OP_AND = 4'd5,
      OP_OR  = 4'd6,
      OP_XOR = 4'd7,
      OP_NOT = 4'd8,
      OP_SHL = 4'd9,
      OP_SHR = 4'd10,
      OP_EQ  = 4'd11
   } op_type;

   // Request word as carried on the input channel.
   typedef struct packed {
      logic [3:0]  req_type;
      logic        b_broadcast;
      logic [63:0] a_lanes_0_1;
      logic [63:0] a_lanes_2_3;
      logic [63:0] a_lanes_4_5;
      logic [63:0] a_lanes_6_7;
      logic [63:0] b_lanes_0_1;
      logic [63:0] b_lanes_2_3;
      logic [63:0] b_lanes_4_5;
      logic [63:0] b_lanes_6_7;
   } req_type_s_type;

   // Response word as carried on the result channel.
   typedef struct packed {
      logic [63:0] r_lanes_0_1;
      logic [63:0] r_lanes_2_3;
      logic [63:0] r_lanes_4_5;
      logic [63:0] r_lanes_6_7;
      logic        all_equal;
      logic        zero_divisor;
   } rsp_type_s_type;

   // Per-item control that travels down the pipeline with the data.
   typedef struct packed {
      logic [3:0] op;
      logic       eq;
      logic       zdiv;
   } ctl_type;

endpackage

// ===== hdl/pvalu_if.sv =====
// Valid/ready channel interface carrying one payload word.
interface pvalu_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/pvalu_div_stage.sv =====
// One restoring-division stage for all eight lanes, resolving four quotient bits.
module pvalu_div_stage (
   input  pvalu_pkg::vec_type rem_in,
   input  pvalu_pkg::vec_type quo_in,
   input  pvalu_pkg::vec_type dvs_in,
   output pvalu_pkg::vec_type rem_out,
   output pvalu_pkg::vec_type quo_out
);

   // Shift in one dividend bit per step and subtract the divisor when it fits.
   always_comb begin
      logic [pvalu_pkg::LANE_W:0] r;
      logic [pvalu_pkg::LANE_W-1:0] q;
      for (int l = 0; l < pvalu_pkg::LANES; l++) begin
         r = {1'b0, rem_in[l]};
         q = quo_in[l];
         for (int s = 0; s < pvalu_pkg::DIV_STEPS; s++) begin
            r = {r[pvalu_pkg::LANE_W-1:0], q[pvalu_pkg::LANE_W-1]};
            q = {q[pvalu_pkg::LANE_W-2:0], 1'b0};
            if (r >= {1'b0, dvs_in[l]}) begin
               r = r - {1'b0, dvs_in[l]};
               q[0] = 1'b1;
            end
         end
         rem_out[l] = r[pvalu_pkg::LANE_W-1:0];
         quo_out[l] = q;
      end
   end

endmodule

// ===== hdl/pvalu_front.sv =====
// Front stage: lane unpacking, broadcast, flags and the operations that need no divider or multiplier.
module pvalu_front (
   input  pvalu_pkg::req_type_s_type req,
   output pvalu_pkg::vec_type        a_vec,
   output pvalu_pkg::vec_type        b_vec,
   output pvalu_pkg::vec_type        simple_vec,
   output pvalu_pkg::ctl_type        ctl
);

   pvalu_pkg::vec_type b_raw;

   // Unpack operands, applying broadcast of lane 0 of b.
   always_comb begin
      a_vec = {req.a_lanes_6_7, req.a_lanes_4_5, req.a_lanes_2_3, req.a_lanes_0_1};
      b_raw = {req.b_lanes_6_7, req.b_lanes_4_5, req.b_lanes_2_3, req.b_lanes_0_1};
      for (int l = 0; l < pvalu_pkg::LANES; l++) begin
         b_vec[l] = req.b_broadcast ? b_raw[0] : b_raw[l];
      end
   end

   // Lane operations that need no more than one adder or shifter.
   always_comb begin
      logic eq_all;
      logic any_zero;
      eq_all = 1'b1;
      any_zero = 1'b0;
      for (int l = 0; l < pvalu_pkg::LANES; l++) begin
         if (a_vec[l] != b_vec[l]) eq_all = 1'b0;
         if (b_vec[l] == '0) any_zero = 1'b1;
         case (req.req_type)
            pvalu_pkg::OP_ADD: simple_vec[l] = a_vec[l] + b_vec[l];
            pvalu_pkg::OP_SUB: simple_vec[l] = a_vec[l] - b_vec[l];
            pvalu_pkg::OP_AND: simple_vec[l] = a_vec[l] & b_vec[l];
            pvalu_pkg::OP_OR:  simple_vec[l] = a_vec[l] | b_vec[l];
            pvalu_pkg::OP_XOR: simple_vec[l] = a_vec[l] ^ b_vec[l];
            pvalu_pkg::OP_NOT: simple_vec[l] = ~a_vec[l];
            pvalu_pkg::OP_SHL: simple_vec[l] = (b_vec[l][31:5] != '0) ? '0 :
                                               (a_vec[l] << b_vec[l][4:0]);
            pvalu_pkg::OP_SHR: simple_vec[l] = (b_vec[l][31:5] != '0) ? '0 :
                                               (a_vec[l] >> b_vec[l][4:0]);
            default:           simple_vec[l] = '0;
         endcase
      end
      ctl.op = req.req_type;
      ctl.eq = (req.req_type == pvalu_pkg::OP_EQ) && eq_all;
      ctl.zdiv = ((req.req_type == pvalu_pkg::OP_DIV) ||
                  (req.req_type == pvalu_pkg::OP_REM)) && any_zero;
   end

endmodule

// ===== hdl/packed_u32x8_vector_alu.sv =====
// Top level of the packed eight-lane 32-bit vector ALU.
//
// One request word on req_ (opcode, broadcast flag, two 256-bit operands)
// gives exactly one response word on rsp_ (256-bit result and two flags).
// Both channels use valid/ready; a word moves when both are high.
//
// The front register is loaded at the accepting edge, then come eight
// divider stages that each resolve four quotient bits in all lanes, then
// the output register, which drives rsp_valid.
// The multiplier product is registered at the front stage.
// Throughput is one word per cycle: a new word enters every cycle while the
// pipeline advances.
//
// The whole pipeline advances as one when the output register is empty or
// being drained; when the receiver stalls, every stage holds and req_ready
// drops only if the output register is full and not taken, so nothing is
// lost or repeated.
//
// Synchronous reset clears all valid bits; no payload is cleared.
module packed_u32x8_vector_alu (
   input logic clock,
   input logic reset,
   pvalu_if.sink   req,
   pvalu_if.source rsp
);

   localparam int NS = pvalu_pkg::DIV_STAGES;

   logic advance;

   pvalu_pkg::vec_type a_vec, b_vec, simple_vec;
   pvalu_pkg::ctl_type ctl_front;

   // Pipeline registers: index 0 is after the front stage.
   logic               valid_ff [NS+1];
   pvalu_pkg::ctl_type ctl_ff   [NS+1];
   pvalu_pkg::vec_type res_ff   [NS+1];   // simple or product result
   pvalu_pkg::vec_type rem_ff   [NS+1];
   pvalu_pkg::vec_type quo_ff   [NS+1];
   pvalu_pkg::vec_type dvs_ff   [NS+1];

   pvalu_pkg::vec_type rem_in [NS];
   pvalu_pkg::vec_type quo_in [NS];

   pvalu_pkg::rsp_type_s_type out_ff, out_in;
   logic                      out_valid_ff;
   pvalu_pkg::vec_type        final_vec;

   // The pipeline moves whenever the output register can take a word.
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   pvalu_front u_front (
      .req        (req.data),
      .a_vec      (a_vec),
      .b_vec      (b_vec),
      .simple_vec (simple_vec),
      .ctl        (ctl_front)
   );

   // Front register: product lanes are formed here, one 32x32 multiply per lane.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req.valid;
      end
      if (advance) begin
         ctl_ff[0] <= ctl_front;
         dvs_ff[0] <= b_vec;
         quo_ff[0] <= a_vec;
         rem_ff[0] <= '0;
         for (int l = 0; l < pvalu_pkg::LANES; l++) begin
            res_ff[0][l] <= (ctl_front.op == pvalu_pkg::OP_MUL) ?
                            pvalu_pkg::lane_type'(a_vec[l] * b_vec[l]) : simple_vec[l];
         end
      end
   end

   // Divider stages.
   for (genvar s = 0; s < NS; s++) begin : g_div
      pvalu_div_stage u_div (
         .rem_in  (rem_ff[s]),
         .quo_in  (quo_ff[s]),
         .dvs_in  (dvs_ff[s]),
         .rem_out (rem_in[s]),
         .quo_out (quo_in[s])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[s+1] <= valid_ff[s];
         end
         if (advance) begin
            ctl_ff[s+1] <= ctl_ff[s];
            res_ff[s+1] <= res_ff[s];
            dvs_ff[s+1] <= dvs_ff[s];
            rem_ff[s+1] <= rem_in[s];
            quo_ff[s+1] <= quo_in[s];
         end
      end
   end

   // Final selection; a zero divisor naturally yields all-ones and the dividend.
   always_comb begin
      for (int l = 0; l < pvalu_pkg::LANES; l++) begin
         case (ctl_ff[NS].op)
            pvalu_pkg::OP_DIV: final_vec[l] = quo_ff[NS][l];
            pvalu_pkg::OP_REM: final_vec[l] = rem_ff[NS][l];
            default:           final_vec[l] = res_ff[NS][l];
         endcase
      end
      out_in.r_lanes_0_1  = {final_vec[1], final_vec[0]};
      out_in.r_lanes_2_3  = {final_vec[3], final_vec[2]};
      out_in.r_lanes_4_5  = {final_vec[5], final_vec[4]};
      out_in.r_lanes_6_7  = {final_vec[7], final_vec[6]};
      out_in.all_equal    = ctl_ff[NS].eq;
      out_in.zero_divisor = ctl_ff[NS].zdiv;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= valid_ff[NS];
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;

endmodule
